>>> src/rxfp_pkg.sv
// Shared types and constants for the receive frame parser.
// Payload structs for both channels, controller/datapath command and status
// structs, register indexes and register reset values. No dependencies.
package rxfp_pkg;

   // Register indexes on the csr_ port
   localparam logic [7:0] CSR_FRAME_HEADER = 8'd0;
   localparam logic [7:0] CSR_STATION_ID   = 8'd1;

   // Register reset values
   localparam logic [7:0]  FRAME_HEADER_RST = 8'hA5;
   localparam logic [15:0] STATION_ID_RST   = 16'd254;

   // Input item kinds
   localparam logic KIND_RX_BYTE = 1'b0;
   localparam logic KIND_TX_DONE = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] frame_id;
      logic [6:0]  payload_len;
      logic [7:0]  data_byte;
      logic        data_valid;
      logic        last;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic hunt_start;
      logic id_take;
      logic len_take;
      logic data_take;
      logic emit_start;
      logic emit_read;
      logic emit_next;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic hdr_match;
      logic id_seen;
      logic len_zero;
      logic len_over;
      logic data_done;
      logic check_ok;
      logic emit_last;
   } status_type;

endpackage

>>> src/rxfp_datapath.sv
// Datapath of the receive frame parser: config registers, running sum,
// frame fields, payload store and the emit read path.
// Depends on rxfp_pkg; driven by rxfp_ctrl through cmd_type.
module rxfp_datapath #(
   parameter int MAX_LEN = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           rx_byte,
   input  logic                 csr_valid,
   input  logic [7:0]           csr_index,
   input  logic [15:0]          csr_wdata,
   input  rxfp_pkg::cmd_type    cmd,
   output rxfp_pkg::status_type status,
   output rxfp_pkg::rsp_type    rsp_data
);

   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   logic [7:0]    header_ff;
   logic [15:0]   station_ff;
   logic [7:0]    sum_ff;
   logic [7:0]    sum_in;
   logic          seen_ff;
   logic [15:0]   ident_ff;
   logic [CW-1:0] len_ff;
   logic [CW-1:0] stored_ff;
   logic [CW-1:0] stored_inc;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] idx_inc;
   logic [7:0]    rd_data_ff;
   logic [7:0]    mem [MAX_LEN];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff  <= rxfp_pkg::FRAME_HEADER_RST;
         station_ff <= rxfp_pkg::STATION_ID_RST;
      end else if (csr_valid) begin
         case (csr_index)
            rxfp_pkg::CSR_FRAME_HEADER: header_ff  <= csr_wdata[7:0];
            rxfp_pkg::CSR_STATION_ID:   station_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign sum_in     = sum_ff + rx_byte;
   assign stored_inc = stored_ff + CW'(1);
   assign idx_inc    = idx_ff + CW'(1);

   // Frame field tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         seen_ff   <= 1'b0;
         ident_ff  <= '0;
         len_ff    <= '0;
         stored_ff <= '0;
         idx_ff    <= '0;
      end else begin
         if (cmd.hunt_start) begin
            sum_ff  <= rx_byte;
            seen_ff <= 1'b0;
         end
         if (cmd.id_take) begin
            sum_ff <= sum_in;
            if (!seen_ff) begin
               ident_ff <= {8'h00, rx_byte};
               seen_ff  <= 1'b1;
            end else begin
               ident_ff[15:8] <= rx_byte;
            end
         end
         if (cmd.len_take) begin
            sum_ff    <= sum_in;
            len_ff    <= CW'(rx_byte);
            stored_ff <= '0;
         end
         if (cmd.data_take) begin
            sum_ff    <= sum_in;
            stored_ff <= stored_inc;
         end
         if (cmd.emit_start) begin
            idx_ff <= '0;
         end
         if (cmd.emit_next) begin
            idx_ff <= idx_inc;
         end
      end
   end

   // Payload store: write on data beats, registered read while emitting
   always_ff @(posedge clock) begin
      if (cmd.data_take) begin
         mem[stored_ff[AW-1:0]] <= rx_byte;
      end
      if (cmd.emit_read) begin
         rd_data_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   // Status back to the controller
   assign status.hdr_match = (rx_byte == header_ff);
   assign status.id_seen   = seen_ff;
   assign status.len_zero  = (rx_byte == 8'h00);
   assign status.len_over  = (rx_byte > 8'(MAX_LEN));
   assign status.data_done = (stored_inc >= len_ff);
   assign status.check_ok  = (rx_byte == sum_ff) && (ident_ff == station_ff);
   assign status.emit_last = (idx_inc >= len_ff);

   // Result beat
   assign rsp_data.frame_id    = ident_ff;
   assign rsp_data.payload_len = 7'(len_ff);
   assign rsp_data.data_valid  = (len_ff != '0);
   assign rsp_data.data_byte   = (len_ff != '0) ? rd_data_ff : 8'h00;
   assign rsp_data.last        = (idx_inc >= len_ff);

endmodule

>>> src/rxfp_ctrl.sv
// Controller of the receive frame parser: parse phase state machine and
// emit sequencer. Depends on rxfp_pkg; drives rxfp_datapath via cmd_type.
module rxfp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_kind,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rxfp_pkg::status_type status,
   output rxfp_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_ID,
      ST_LEN,
      ST_DATA,
      ST_CHECK,
      ST_EMIT_RD,
      ST_EMIT_SHOW
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rx_beat;

   assign req_ready = (state_ff != ST_EMIT_RD) && (state_ff != ST_EMIT_SHOW);
   assign rsp_valid = (state_ff == ST_EMIT_SHOW);
   assign rx_beat   = req_valid && req_ready && (req_kind == rxfp_pkg::KIND_RX_BYTE);

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      if (req_valid && req_ready && (req_kind == rxfp_pkg::KIND_TX_DONE)) begin
         state_in = ST_HUNT;
      end
      case (state_ff)
         ST_ID: begin
            if (rx_beat) begin
               cmd.id_take = 1'b1;
               if (status.id_seen) state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            if (rx_beat) begin
               cmd.len_take = 1'b1;
               if (status.len_over)      state_in = ST_HUNT;
               else if (status.len_zero) state_in = ST_CHECK;
               else                      state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (rx_beat) begin
               cmd.data_take = 1'b1;
               if (status.data_done) state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (rx_beat) begin
               if (status.check_ok) begin
                  cmd.emit_start = 1'b1;
                  state_in       = ST_EMIT_RD;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_EMIT_RD: begin
            cmd.emit_read = 1'b1;
            state_in      = ST_EMIT_SHOW;
         end
         ST_EMIT_SHOW: begin
            if (rsp_ready) begin
               if (status.emit_last) begin
                  state_in = ST_HUNT;
               end else begin
                  cmd.emit_next = 1'b1;
                  state_in      = ST_EMIT_RD;
               end
            end
         end
         default: begin
            if (rx_beat && status.hdr_match) begin
               cmd.hunt_start = 1'b1;
               state_in       = ST_ID;
            end
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Input is held off for the whole of an emit run
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("input accepted while a result is pending");

   // A store read is always followed by a result beat
   a_read_then_show: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_read |=> rsp_valid)
      else $error("store read not followed by a result");

   // At most one datapath command per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("conflicting datapath commands");

endmodule

>>> src/rx_frame_parser_sum8_id_filter_core.sv
// Top level of the receive frame parser with 8-bit sum check and id filter.
// Depends on rxfp_pkg; instantiates rxfp_ctrl and rxfp_datapath.
//
// Usage:
//   req_ channel: one beat per received line byte (kind 0) or a transmit
//   finished marker (kind 1) that sends the parser back to header hunt.
//   Frames are header, id low, id high, length, payload, checksum.
//   rsp_ channel: for a frame whose checksum and id match, one beat per
//   payload byte (last marked), or one beat without data for an empty frame.
//   csr_ channel: index 0 writes the header byte, 1 the station id;
//   csr_ready is always high, other indexes are dropped.
// Data flow:
//   While parsing, one input beat is taken every cycle. After an accepted
//   checksum byte, the payload is read out of the store byte by byte: for
//   each byte a registered store read, then the result beat. req_ready
//   stays low for the whole emit run, and a stalled rsp_ready simply holds
//   the current beat.
// Reset: synchronous, clears the parser to header hunt and restores the
//   register defaults (header 0xA5, station id 254).
module rx_frame_parser_sum8_id_filter_core #(
   parameter int MAX_LEN = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rxfp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rxfp_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   rxfp_pkg::cmd_type    cmd;
   rxfp_pkg::status_type status;

   assign csr_ready = 1'b1;

   rxfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rxfp_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .rx_byte   (req_data.rx_byte),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
